### src/owo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Omni odometry package
// Shared constants, sequencer states and the CORDIC arctangent table of the
// three-wheel omni odometry block.
// ----------------------------------------------------------------------------
package owo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int NUM_WHEELS   = 3;
  localparam int NUM_REGS     = 6;

  // Configuration register indexes.
  localparam logic [2:0] REG_ANGLE0 = 3'd0;
  localparam logic [2:0] REG_ANGLE1 = 3'd1;
  localparam logic [2:0] REG_ANGLE2 = 3'd2;
  localparam logic [2:0] REG_CPR    = 3'd3;
  localparam logic [2:0] REG_WRAD   = 3'd4;
  localparam logic [2:0] REG_BRAD   = 3'd5;

  // Operation codes.
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // 2*pi in Q28 and the CORDIC gain compensation in Q30.
  localparam logic [30:0]        TWOPI_Q28       = 31'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // Divisor 3 * 2^23 for the body motion, and half of it for rounding.
  localparam logic [44:0] BODY_DIV  = 45'd25165824;
  localparam logic [44:0] BODY_HALF = 45'd12582912;

  // Iteration counts of the shared units, as last counter values.
  localparam logic [6:0] MUL_LAST = 7'd31;
  localparam logic [6:0] DIV_LAST = 7'd67;
  localparam logic [6:0] COR_LAST = 7'(CORDIC_STEPS - 1);

  typedef enum logic [4:0] {
    S_IDLE,
    S_W_MUL1,
    S_W_MUL2,
    S_W_DIV,
    S_W_COR,
    S_W_MULS,
    S_W_MULC,
    S_B_DIVX,
    S_B_DIVY,
    S_H_MUL1,
    S_H_MUL2,
    S_H_DIV,
    S_P_COR,
    S_P_MUL0,
    S_P_MUL1,
    S_P_MUL2,
    S_P_MUL3,
    S_FIN,
    S_OUT
  } owo_state_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### src/omni_three_wheel_odometry.sv
`default_nettype none
// One item at a time: a new item is taken only in the idle state, after the last
// result has gone to the output register. A clear item or a skipped step goes
// straight to the output; a step with body_radius zero skips the heading math.
// The serial multiplier, restoring divider and CORDIC (24 iterations) are shared.
// Reset: synchronous, active low; pose cleared, registers to their defaults.
// ----------------------------------------------------------------------------
// Three-wheel omni odometry
// Converts encoder deltas to wheel travel, applies the forward kinematics and
// integrates a fixed-point pose using shared multiply, divide and CORDIC units.
// ----------------------------------------------------------------------------
module omni_three_wheel_odometry
  import owo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic signed [15:0] in_wheel_delta_0,
  input  logic signed [15:0] in_wheel_delta_1,
  input  logic signed [15:0] in_wheel_delta_2,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading,
  output logic               out_skipped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  // Configuration registers.
  logic [15:0] cfg_r [NUM_REGS];

  // Sequencer.
  owo_state_t state_r, state_nxt;
  logic       busy_r, busy_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [1:0] wheel_r, wheel_nxt;

  // Latched item.
  logic signed [15:0] delta_r [NUM_WHEELS];
  logic signed [17:0] dsum_r;

  // Serial multiplier.
  logic [71:0] mul_a_r, mul_a_nxt, acc_r, acc_nxt;
  logic [31:0] mul_b_r, mul_b_nxt;
  logic        mul_neg_r, mul_neg_nxt;

  // Restoring divider.
  logic [67:0] div_n_r, div_n_nxt;
  logic [44:0] div_d_r, div_d_nxt, div_rem_r, div_rem_nxt;
  logic [39:0] div_q_r, div_q_nxt;

  // CORDIC.
  logic signed [33:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic               flip_r, flip_nxt;

  // Intermediate results.
  logic signed [28:0] wc_r, wc_nxt, ws_r, ws_nxt, c_r, c_nxt, s_r, s_nxt;
  logic signed [63:0] sx_r, sx_nxt, sy_r, sy_nxt, tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [40:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [33:0]        m_r, m_nxt;
  logic [31:0]        full_r, full_nxt, half_r, half_nxt;

  // Pose.
  logic signed [31:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic [31:0]        pose_h_r, pose_h_nxt;
  logic               skip_r, skip_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [31:0]        out_h_r, out_h_nxt;
  logic               out_skip_r, out_skip_nxt;

  logic in_acc;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_x_r;
  assign out_pos_y   = out_y_r;
  assign out_heading = out_h_r;
  assign out_skipped = out_skip_r;

  // Helpers.
  function automatic logic [27:0] mag29(input logic signed [28:0] v);
    logic signed [28:0] n;
    n = -v;
    return v[28] ? n[27:0] : v[27:0];
  endfunction

  function automatic logic [39:0] mag41(input logic signed [40:0] v);
    logic signed [40:0] n;
    n = -v;
    return v[40] ? n[39:0] : v[39:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? n : v;
  endfunction

  // Round a Q30 CORDIC output to Q24, ties away from zero.
  function automatic logic signed [28:0] trig_rnd(input logic signed [33:0] v);
    logic signed [33:0] n;
    logic [33:0]        mg;
    logic [33:0]        q;
    logic signed [28:0] r;
    n  = -v;
    mg = v[33] ? n : v;
    q  = (mg + 34'd32) >> 6;
    r  = signed'(q[28:0]);
    return v[33] ? -r : r;
  endfunction

  // Round a Q32 world motion to Q8, ties away from zero.
  function automatic logic signed [40:0] rnd24(input logic signed [63:0] v);
    logic [63:0]        mg;
    logic [63:0]        q;
    logic signed [40:0] r;
    mg = mag64(v);
    q  = (mg + 64'd8388608) >> 24;
    r  = signed'(q[40:0]);
    return v[63] ? -r : r;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [40:0] d);
    logic signed [41:0] s;
    s = 42'(p) + 42'(d);
    if (s > 42'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -42'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // Current wheel and register views.
  logic signed [15:0] dc_cur;
  logic [15:0]        dc_mag, cpr, rad, body;
  logic [16:0]        dsum_mag;
  logic signed [17:0] dsum_neg;
  assign dc_cur   = delta_r[wheel_r];
  assign dc_mag   = dc_cur[15] ? 16'(-dc_cur) : dc_cur;
  assign cpr      = cfg_r[REG_CPR];
  assign rad      = cfg_r[REG_WRAD];
  assign body     = cfg_r[REG_BRAD];
  assign dsum_neg = -dsum_r;
  assign dsum_mag = dsum_r[17] ? dsum_neg[16:0] : dsum_r[16:0];

  // Multiplier step.
  logic [71:0]        mul_sum;
  logic signed [63:0] mul_sp;
  assign mul_sum = acc_r + (mul_b_r[0] ? mul_a_r : 72'd0);
  assign mul_sp  = mul_neg_r ? -signed'(mul_sum[63:0]) : signed'(mul_sum[63:0]);

  // Divider step.
  logic [45:0] div_sh;
  logic        div_ge;
  logic [44:0] div_rem_new;
  logic [39:0] div_q_new;
  assign div_sh      = {div_rem_r, div_n_r[67]};
  assign div_ge      = div_sh >= {1'b0, div_d_r};
  assign div_rem_new = div_ge ? 45'(div_sh - {1'b0, div_d_r}) : div_sh[44:0];
  assign div_q_new   = {div_q_r[38:0], div_ge};

  // CORDIC step.
  logic [4:0]         cor_i;
  logic signed [33:0] cor_dx, cor_dy, cor_at, cor_x, cor_y, cor_z, cor_fx, cor_fy;
  assign cor_i  = cnt_r[4:0];
  assign cor_dx = cy_r >>> cor_i;
  assign cor_dy = cx_r >>> cor_i;
  assign cor_at = signed'({2'b00, atan_turn(cor_i)});

  always_comb begin
    if (!cz_r[33]) begin
      cor_x = cx_r - cor_dx;
      cor_y = cy_r + cor_dy;
      cor_z = cz_r - cor_at;
    end else begin
      cor_x = cx_r + cor_dx;
      cor_y = cy_r - cor_dy;
      cor_z = cz_r + cor_at;
    end
    cor_fx = flip_r ? -cor_x : cor_x;
    cor_fy = flip_r ? -cor_y : cor_y;
  end

  // Operand selection for the shared units.
  logic [39:0] ld_a;
  logic [31:0] ld_b;
  logic        ld_neg;
  logic [67:0] ld_n;
  logic [44:0] ld_d;
  logic [31:0] ld_ang;
  logic [33:0] den34;

  assign den34 = {2'b00, acc_r[31:0]} + {1'b0, acc_r[31:0], 1'b0};

  always_comb begin
    ld_a   = '0;
    ld_b   = '0;
    ld_neg = 1'b0;
    ld_n   = '0;
    ld_d   = '0;
    ld_ang = '0;
    case (state_r)
      S_W_MUL1: begin
        ld_a = 40'(dc_mag);
        ld_b = 32'(rad);
      end
      S_W_MUL2: begin
        ld_a = 40'(acc_r[31:0]);
        ld_b = 32'(TWOPI_Q28);
      end
      S_W_MULS: begin
        ld_a   = div_q_r;
        ld_b   = 32'(mag29(ws_r));
        ld_neg = dc_cur[15] ^ ws_r[28];
      end
      S_W_MULC: begin
        ld_a   = div_q_r;
        ld_b   = 32'(mag29(wc_r));
        ld_neg = dc_cur[15] ^ wc_r[28];
      end
      S_H_MUL1: begin
        ld_a = 40'(dsum_mag);
        ld_b = 32'(rad);
      end
      S_H_MUL2: begin
        ld_a = 40'(body);
        ld_b = 32'(cpr);
      end
      S_P_MUL0: begin
        ld_a   = mag41(bx_r);
        ld_b   = 32'(mag29(c_r));
        ld_neg = bx_r[40] ^ c_r[28];
      end
      S_P_MUL1: begin
        ld_a   = mag41(by_r);
        ld_b   = 32'(mag29(s_r));
        ld_neg = by_r[40] ^ s_r[28];
      end
      S_P_MUL2: begin
        ld_a   = mag41(bx_r);
        ld_b   = 32'(mag29(s_r));
        ld_neg = bx_r[40] ^ s_r[28];
      end
      S_P_MUL3: begin
        ld_a   = mag41(by_r);
        ld_b   = 32'(mag29(c_r));
        ld_neg = by_r[40] ^ c_r[28];
      end
      S_W_DIV: begin
        ld_n = 68'(acc_r[62:0]) + 68'({cpr, 27'd0});
        ld_d = 45'({cpr, 28'd0});
      end
      S_B_DIVX: begin
        ld_n = 68'(mag64(sx_r)) + 68'(BODY_HALF);
        ld_d = BODY_DIV;
      end
      S_B_DIVY: begin
        ld_n = 68'(mag64(sy_r)) + 68'(BODY_HALF);
        ld_d = BODY_DIV;
      end
      S_H_DIV: begin
        ld_n = 68'({m_r, 32'd0}) + 68'(den34 >> 1);
        ld_d = 45'(den34);
      end
      S_W_COR: ld_ang = {cfg_r[{1'b0, wheel_r}], 16'd0};
      S_P_COR: ld_ang = pose_h_r + half_r;
      default: ld_ang = '0;
    endcase
  end

  // CORDIC start values: fold the angle into the right half plane.
  logic [31:0]        ang_rot;
  logic               ang_flip;
  logic [31:0]        ang_zu;
  logic signed [33:0] ang_z;
  assign ang_rot  = ld_ang + 32'h40000000;
  assign ang_flip = ang_rot[31];
  assign ang_zu   = ang_flip ? ld_ang - 32'h80000000 : ld_ang;
  assign ang_z    = signed'({{2{ang_zu[31]}}, ang_zu});

  // Rounded heading change and final world motion.
  logic [32:0]        q33;
  logic signed [40:0] bq;
  logic signed [40:0] rx, ry;
  assign q33 = div_q_new[32:0];
  assign bq  = signed'({1'b0, div_q_new});
  assign rx  = rnd24(tx_r);
  assign ry  = rnd24(ty_r);

  // Sequencer: next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    wheel_nxt     = wheel_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    acc_nxt       = acc_r;
    mul_neg_nxt   = mul_neg_r;
    div_n_nxt     = div_n_r;
    div_d_nxt     = div_d_r;
    div_rem_nxt   = div_rem_r;
    div_q_nxt     = div_q_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    flip_nxt      = flip_r;
    wc_nxt        = wc_r;
    ws_nxt        = ws_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    m_nxt         = m_r;
    full_nxt      = full_r;
    half_nxt      = half_r;
    pose_x_nxt    = pose_x_r;
    pose_y_nxt    = pose_y_r;
    pose_h_nxt    = pose_h_r;
    skip_nxt      = skip_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_h_nxt     = out_h_r;
    out_skip_nxt  = out_skip_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          busy_nxt = 1'b0;
          if (in_operation == OP_CLEAR) begin
            pose_x_nxt = '0;
            pose_y_nxt = '0;
            pose_h_nxt = '0;
            skip_nxt   = 1'b0;
            state_nxt  = S_OUT;
          end else if (cpr == 16'd0) begin
            skip_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            skip_nxt  = 1'b0;
            wheel_nxt = '0;
            sx_nxt    = '0;
            sy_nxt    = '0;
            state_nxt = S_W_MUL1;
          end
        end
      end

      // Serial multiplier: one bit of the B operand per cycle.
      S_W_MUL1, S_W_MUL2, S_W_MULS, S_W_MULC, S_H_MUL1, S_H_MUL2,
      S_P_MUL0, S_P_MUL1, S_P_MUL2, S_P_MUL3: begin
        if (!busy_r) begin
          mul_a_nxt   = 72'(ld_a);
          mul_b_nxt   = ld_b;
          mul_neg_nxt = ld_neg;
          acc_nxt     = '0;
          cnt_nxt     = '0;
          busy_nxt    = 1'b1;
        end else begin
          acc_nxt   = mul_sum;
          mul_a_nxt = {mul_a_r[70:0], 1'b0};
          mul_b_nxt = {1'b0, mul_b_r[31:1]};
          cnt_nxt   = cnt_r + 7'd1;
          if (cnt_r == MUL_LAST) begin
            busy_nxt = 1'b0;
            case (state_r)
              S_W_MUL1: state_nxt = S_W_MUL2;
              S_W_MUL2: state_nxt = S_W_DIV;
              S_W_MULS: begin
                sx_nxt    = sx_r - mul_sp;
                state_nxt = S_W_MULC;
              end
              S_W_MULC: begin
                sy_nxt = sy_r + mul_sp;
                if (wheel_r == 2'(NUM_WHEELS - 1)) begin
                  state_nxt = S_B_DIVX;
                end else begin
                  wheel_nxt = wheel_r + 2'd1;
                  state_nxt = S_W_MUL1;
                end
              end
              S_H_MUL1: begin
                m_nxt     = mul_sum[33:0];
                state_nxt = S_H_MUL2;
              end
              S_H_MUL2: state_nxt = S_H_DIV;
              S_P_MUL0: begin
                tx_nxt    = mul_sp;
                state_nxt = S_P_MUL1;
              end
              S_P_MUL1: begin
                tx_nxt    = tx_r - mul_sp;
                state_nxt = S_P_MUL2;
              end
              S_P_MUL2: begin
                ty_nxt    = mul_sp;
                state_nxt = S_P_MUL3;
              end
              default: begin
                ty_nxt    = ty_r + mul_sp;
                state_nxt = S_FIN;
              end
            endcase
          end
        end
      end

      // Restoring divider: one quotient bit per cycle.
      S_W_DIV, S_B_DIVX, S_B_DIVY, S_H_DIV: begin
        if (!busy_r) begin
          div_n_nxt   = ld_n;
          div_d_nxt   = ld_d;
          div_rem_nxt = '0;
          div_q_nxt   = '0;
          cnt_nxt     = '0;
          busy_nxt    = 1'b1;
        end else begin
          div_n_nxt   = {div_n_r[66:0], 1'b0};
          div_rem_nxt = div_rem_new;
          div_q_nxt   = div_q_new;
          cnt_nxt     = cnt_r + 7'd1;
          if (cnt_r == DIV_LAST) begin
            busy_nxt = 1'b0;
            case (state_r)
              S_W_DIV: state_nxt = S_W_COR;
              S_B_DIVX: begin
                bx_nxt    = sx_r[63] ? -bq : bq;
                state_nxt = S_B_DIVY;
              end
              S_B_DIVY: begin
                by_nxt = sy_r[63] ? -bq : bq;
                if (body != 16'd0) begin
                  state_nxt = S_H_MUL1;
                end else begin
                  full_nxt  = '0;
                  half_nxt  = '0;
                  state_nxt = S_P_COR;
                end
              end
              default: begin
                full_nxt  = dsum_r[17] ? -q33[31:0] : q33[31:0];
                half_nxt  = dsum_r[17] ? -q33[32:1] : q33[32:1];
                state_nxt = S_P_COR;
              end
            endcase
          end
        end
      end

      // CORDIC rotation: one micro-rotation per cycle.
      S_W_COR, S_P_COR: begin
        if (!busy_r) begin
          cx_nxt   = CORDIC_GAIN_Q30;
          cy_nxt   = '0;
          cz_nxt   = ang_z;
          flip_nxt = ang_flip;
          cnt_nxt  = '0;
          busy_nxt = 1'b1;
        end else begin
          cx_nxt  = cor_x;
          cy_nxt  = cor_y;
          cz_nxt  = cor_z;
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == COR_LAST) begin
            busy_nxt = 1'b0;
            if (state_r == S_W_COR) begin
              wc_nxt    = trig_rnd(cor_fx);
              ws_nxt    = trig_rnd(cor_fy);
              state_nxt = S_W_MULS;
            end else begin
              c_nxt     = trig_rnd(cor_fx);
              s_nxt     = trig_rnd(cor_fy);
              state_nxt = S_P_MUL0;
            end
          end
        end
      end

      // Commit the integrated pose.
      S_FIN: begin
        pose_x_nxt = sat_add(pose_x_r, rx);
        pose_y_nxt = sat_add(pose_y_r, ry);
        pose_h_nxt = pose_h_r + full_r;
        state_nxt  = S_OUT;
      end

      // Hand the result item to the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = pose_x_r;
          out_y_nxt     = pose_y_r;
          out_h_nxt     = pose_h_r;
          out_skip_nxt  = skip_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and pose.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      busy_r            <= 1'b0;
      cnt_r             <= '0;
      wheel_r           <= '0;
      out_valid_r       <= 1'b0;
      pose_x_r          <= '0;
      pose_y_r          <= '0;
      pose_h_r          <= '0;
      skip_r            <= 1'b0;
      cfg_r[REG_ANGLE0] <= 16'd0;
      cfg_r[REG_ANGLE1] <= 16'd21845;
      cfg_r[REG_ANGLE2] <= 16'd43691;
      cfg_r[REG_CPR]    <= 16'd0;
      cfg_r[REG_WRAD]   <= 16'd0;
      cfg_r[REG_BRAD]   <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      wheel_r     <= wheel_nxt;
      out_valid_r <= out_valid_nxt;
      pose_x_r    <= pose_x_nxt;
      pose_y_r    <= pose_y_nxt;
      pose_h_r    <= pose_h_nxt;
      skip_r      <= skip_nxt;
      if (cfg_we && (cfg_index <= REG_BRAD)) begin
        cfg_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    acc_r      <= acc_nxt;
    mul_neg_r  <= mul_neg_nxt;
    div_n_r    <= div_n_nxt;
    div_d_r    <= div_d_nxt;
    div_rem_r  <= div_rem_nxt;
    div_q_r    <= div_q_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    flip_r     <= flip_nxt;
    wc_r       <= wc_nxt;
    ws_r       <= ws_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    m_r        <= m_nxt;
    full_r     <= full_nxt;
    half_r     <= half_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_h_r    <= out_h_nxt;
    out_skip_r <= out_skip_nxt;
    if (in_acc) begin
      delta_r[0] <= in_wheel_delta_0;
      delta_r[1] <= in_wheel_delta_1;
      delta_r[2] <= in_wheel_delta_2;
      dsum_r     <= 18'(in_wheel_delta_0) + 18'(in_wheel_delta_1)
                    + 18'(in_wheel_delta_2);
    end
  end

endmodule
`default_nettype wire

### verif/omni_three_wheel_odometry_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Omni odometry checker
// Watches the configuration port and both channels of the odometry block,
// predicts the pose after every accepted item and compares each result item.
// ----------------------------------------------------------------------------
module omni_three_wheel_odometry_checker
  import owo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_operation,
  input  logic signed [15:0] in_wheel_delta_0,
  input  logic signed [15:0] in_wheel_delta_1,
  input  logic signed [15:0] in_wheel_delta_2,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_y,
  input  logic [31:0]        out_heading,
  input  logic               out_skipped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic               skipped;
  } pose_t;

  logic [15:0]        shadow_reg [NUM_REGS];
  logic signed [31:0] odo_x;
  logic signed [31:0] odo_y;
  logic [31:0]        odo_heading;
  pose_t              pose_queue [$];

  assign pending = pose_queue.size();

  // Arctangent of 2^-i in 2^-32 turn, from a Taylor series at Q62.
  function automatic longint unsigned arctan_turns(int i);
    longint unsigned t, pos, neg, r32, term;
    int k;
    pos = 0;
    neg = 0;
    k = 0;
    if (i == 0) return 64'h2000_0000;
    t = 64'd1 << (62 - i);
    while (t != 0) begin
      term = t / (2 * k + 1);
      if (k % 2 == 0) pos += term;
      else neg += term;
      t >>= 2 * i;
      k++;
    end
    r32 = (pos - neg + (64'd1 << 29)) >> 30;
    return (r32 * 64'd683565276 + (64'd1 << 31)) >> 32;
  endfunction

  // Signed division rounded to nearest, ties away from zero.
  function automatic wide_t div_round(wide_t num, logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = num[127] ? 128'(-num) : 128'(num);
    q = (mag + den / 2) / den;
    return num[127] ? -$signed(q) : $signed(q);
  endfunction

  // Cosine and sine of an angle in 2^-32 turn, Q24.
  task automatic rotate_unit(input logic [31:0] angle, output wide_t c, output wide_t s);
    logic [31:0] shifted;
    logic [31:0] zu;
    logic        flip;
    longint      z, x, y, dx, dy, at;
    shifted = angle + 32'h4000_0000;
    flip = shifted[31];
    zu = flip ? angle - 32'h8000_0000 : angle;
    z = $signed(zu);
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      at = longint'(arctan_turns(i));
      if (z >= 0) begin
        x -= dx; y += dy; z -= at;
      end else begin
        x += dx; y -= dy; z += at;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = div_round(wide_t'(x), 128'd64);
    s = div_round(wide_t'(y), 128'd64);
  endtask

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] p, wide_t d);
    wide_t v;
    v = wide_t'(p) + d;
    if (v > wide_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -wide_t'(64'sd2147483648)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Advance the pose by one item and return the expected result.
  task automatic advance_pose(input logic op, input logic signed [15:0] d0,
                              input logic signed [15:0] d1, input logic signed [15:0] d2,
                              output pose_t res);
    logic [63:0]        cpr, rad, body, m, den, qh, r, q1, q2, q33;
    logic signed [15:0] dc [3];
    wide_t              sx, sy, bx, by, c, s, d, wc, ws;
    int                 dsum;
    logic [31:0]        full, half;
    cpr = shadow_reg[REG_CPR];
    rad = shadow_reg[REG_WRAD];
    body = shadow_reg[REG_BRAD];
    dc[0] = d0; dc[1] = d1; dc[2] = d2;
    res.skipped = 1'b0;
    if (op == OP_CLEAR) begin
      odo_x = 0; odo_y = 0; odo_heading = 0;
    end else if (cpr == 0) begin
      res.skipped = 1'b1;
    end else begin
      sx = 0; sy = 0; dsum = 0; full = 0; half = 0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        d = div_round(wide_t'(dc[i]) * wide_t'(rad) * wide_t'(64'd1686629713),
                      128'(cpr) << 28);
        rotate_unit({shadow_reg[i], 16'h0000}, wc, ws);
        sx -= d * ws;
        sy += d * wc;
        dsum += int'(dc[i]);
      end
      bx = div_round(sx, 128'd3 << 23);
      by = div_round(sy, 128'd3 << 23);
      // Heading change as a long division in 16-bit digits.
      if (body != 0) begin
        m = 64'(dsum < 0 ? -dsum : dsum) * rad;
        den = 3 * body * cpr;
        qh = m / den; r = m % den;
        r <<= 16; q1 = r / den; r %= den;
        r <<= 16; q2 = r / den; r %= den;
        q33 = ((qh & 1) << 32) | (q1 << 16) | q2;
        if (2 * r >= den) q33++;
        q33 &= 64'h1_FFFF_FFFF;
        full = q33[31:0];
        half = q33[32:1];
        if (dsum < 0) begin
          full = -full; half = -half;
        end
      end
      rotate_unit(odo_heading + half, c, s);
      odo_x = sat_sum(odo_x, div_round(bx * c - by * s, 128'd1 << 24));
      odo_y = sat_sum(odo_y, div_round(bx * s + by * c, 128'd1 << 24));
      odo_heading += full;
    end
    res.pos_x = odo_x;
    res.pos_y = odo_y;
    res.heading = odo_heading;
  endtask

  // Track registers, predict on input items and compare result items.
  always @(posedge clk) begin
    pose_t got, want;
    if (!rst_n) begin
      shadow_reg[REG_ANGLE0] <= 16'd0;
      shadow_reg[REG_ANGLE1] <= 16'd21845;
      shadow_reg[REG_ANGLE2] <= 16'd43691;
      shadow_reg[REG_CPR] <= 16'd0;
      shadow_reg[REG_WRAD] <= 16'd0;
      shadow_reg[REG_BRAD] <= 16'd0;
      odo_x = 0; odo_y = 0; odo_heading = 0;
      pose_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we && cfg_index < NUM_REGS) shadow_reg[cfg_index] <= cfg_wdata;
      if (in_valid && in_ready) begin
        advance_pose(in_operation, in_wheel_delta_0, in_wheel_delta_1,
                     in_wheel_delta_2, want);
        pose_queue.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.pos_x = out_pos_x;
        got.pos_y = out_pos_y;
        got.heading = out_heading;
        got.skipped = out_skipped;
        if (pose_queue.size() == 0) begin
          $display("%0t: unexpected item x=%0d y=%0d h=%h s=%b", $time,
                   got.pos_x, got.pos_y, got.heading, got.skipped);
          fail_count <= fail_count + 1;
        end else begin
          want = pose_queue.pop_front();
          if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
              got.heading !== want.heading || got.skipped !== want.skipped) begin
            $display("%0t: expected x=%0d y=%0d h=%h s=%b, actual x=%0d y=%0d h=%h s=%b",
                     $time, want.pos_x, want.pos_y, want.heading, want.skipped,
                     got.pos_x, got.pos_y, got.heading, got.skipped);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### verif/omni_three_wheel_odometry_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Omni odometry testbench
// Drives directed and random odometry items through several register settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module omni_three_wheel_odometry_test
  import owo_pkg::*;
();

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_operation;
  logic signed [15:0] in_wheel_delta_0;
  logic signed [15:0] in_wheel_delta_1;
  logic signed [15:0] in_wheel_delta_2;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic [31:0]        out_heading;
  logic               out_skipped;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  logic               hold_req;
  logic               hold_taken;
  int                 hold_cnt;
  longint             cycle_count;

  omni_three_wheel_odometry DUT (.*);

  omni_three_wheel_odometry_checker checker_i (.*);

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= 4000;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd20_000_000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one item and wait until it is accepted.
  task automatic send_item(input logic op, input logic signed [15:0] d0,
                           input logic signed [15:0] d1, input logic signed [15:0] d2);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_wheel_delta_0 <= d0;
    in_wheel_delta_1 <= d1;
    in_wheel_delta_2 <= d2;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let the block drain, then write all registers.
  task automatic write_regs(input logic [15:0] a0, input logic [15:0] a1,
                            input logic [15:0] a2, input logic [15:0] cpr,
                            input logic [15:0] wrad, input logic [15:0] brad);
    logic [15:0] vals [NUM_REGS];
    vals = '{a0, a1, a2, cpr, wrad, brad};
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_delta();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'sd0 + 16'($urandom_range(600)) - 16'sd300;
  endfunction

  // Stimulus.
  initial begin
    logic [15:0] cpr, brad;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_STEP;
    in_wheel_delta_0 = 0;
    in_wheel_delta_1 = 0;
    in_wheel_delta_2 = 0;
    cfg_we = 1'b0;
    cfg_index = REG_ANGLE0;
    cfg_wdata = 0;
    hold_req = 1'b0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: steps are skipped while counts per rev is zero.
    send_item(OP_STEP, 16'sd100, -16'sd5, 16'sd7);
    send_item(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0);

    // Typical base.
    write_regs(16'd0, 16'd21845, 16'd43691, 16'd1024, 16'd12800, 16'd38400);
    send_item(OP_STEP, 16'sd0, 16'sd0, 16'sd0);
    send_item(OP_STEP, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(OP_STEP, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(OP_STEP, 16'sd500, -16'sd250, -16'sd250);
    send_item(OP_STEP, -16'sd32768, 16'sd32767, 16'sd1);
    send_item(OP_CLEAR, 16'sd1234, -16'sd1, 16'sd9);
    send_item(OP_STEP, 16'sd1, 16'sd2, 16'sd3);

    // No rotation.
    write_regs(16'd16384, 16'd65535, 16'd32768, 16'd65535, 16'd256, 16'd0);
    send_item(OP_STEP, 16'sd32767, -16'sd32768, 16'sd0);
    send_item(OP_STEP, -16'sd1, -16'sd1, -16'sd1);

    // Largest travel: position saturates, heading wraps.
    write_regs(16'd65535, 16'd0, 16'd32768, 16'd1, 16'd65535, 16'd1);
    send_item(OP_STEP, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(OP_STEP, 16'sd32767, 16'sd32767, 16'sd32767);
    send_item(OP_STEP, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(OP_STEP, -16'sd32768, -16'sd32768, -16'sd32768);
    send_item(OP_STEP, -16'sd32768, 16'sd100, 16'sd32767);
    send_item(OP_CLEAR, 16'sd0, 16'sd0, 16'sd0);

    // Random part over several settings and idling modes.
    for (int item_no = 0; item_no < 1550; item_no++) begin
      if (item_no % 220 == 0) begin
        cpr = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
        if ($urandom_range(2) == 0) cpr = 16'($urandom_range(1, 64));
        brad = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom);
        write_regs(16'($urandom), 16'($urandom), 16'($urandom), cpr,
                   16'($urandom), brad);
      end
      if (item_no < 520) begin
        send_idle_pct = 11; recv_idle_pct = 65;
      end else if (item_no < 1040) begin
        send_idle_pct = 65; recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (item_no == 300) hold_req <= 1'b1;
      send_item(($urandom_range(19) == 0) ? OP_CLEAR : OP_STEP,
                rand_delta(), rand_delta(), rand_delta());
    end
    in_valid <= 1'b0;

    // Drain.
    while (pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
src/owo_pkg.sv
src/omni_three_wheel_odometry.sv
verif/omni_three_wheel_odometry_checker.sv
verif/omni_three_wheel_odometry_test.sv
